@@ design/peu_pkg.sv @@
package peu_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned NumStages = 19;
  localparam int unsigned DivFirst = 1;
  localparam int unsigned DivLast = 16;
  localparam int unsigned LerpStage = 17;
  localparam int unsigned KickStage = 5;
  localparam int unsigned WindStage = 6;
  localparam int unsigned DampStage = 7;
  localparam int unsigned PosStage = 8;

  localparam int unsigned Tenth = ((1 << FracBits) + 5) / 10;
  localparam int unsigned AlphaZero = ((1 << FracBits) * 4 + 2) / 5;
  localparam int unsigned SizeZero = (1 << FracBits) * 100;
  localparam int unsigned SizeEnd = (1 << FracBits) * 10;
  localparam int unsigned Recip6 = 43691;
  localparam int unsigned Recip6Shift = 18;

  typedef enum logic [2:0] {
    CfgDeltaTime = 3'd0,
    CfgWindX     = 3'd1,
    CfgWindY     = 3'd2,
    CfgWindZ     = 3'd3,
    CfgWindStr   = 3'd4,
    CfgHumidity  = 3'd5
  } cfg_reg_e;

  typedef logic signed [31:0] s32_t;

  typedef struct {
    logic        live;
    s32_t        pos [3];
    s32_t        vel [3];
    logic [30:0] age;
    logic [30:0] life;
    logic [31:0] rem;
    logic [15:0] quo;
    logic [22:0] size;
    logic [15:0] alpha;
  } pe_st_t;

  typedef struct {
    logic [16:0]        dt;
    logic [13:0]        kick;
    logic signed [28:0] wind [3];
    logic signed [18:0] fac;
  } pe_dcfg_t;

  function automatic s32_t sat32(input logic signed [35:0] v);
    s32_t r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic pe_st_t pe_step(input int unsigned k, input pe_st_t a,
                                     input pe_dcfg_t c);
    pe_st_t             o;
    logic [31:0]        asum;
    logic [30:0]        agen;
    logic [32:0]        r2;
    logic               qb;
    logic [22:0]        n90;
    logic [31:0]        am;
    logic signed [50:0] mf;
    logic signed [49:0] mp;
    o = a;
    if (k == 0) begin
      asum = {1'b0, a.age} + 32'(c.dt);
      agen = asum[31] ? 31'h7fffffff : asum[30:0];
      o.age = agen;
      o.live = agen < a.life;
      o.rem = {1'b0, agen};
      o.quo = '0;
    end
    if (k >= DivFirst && k <= DivLast) begin
      r2 = {a.rem, 1'b0};
      qb = 1'b0;
      if (r2 >= {2'b00, a.life}) begin
        r2 = r2 - {2'b00, a.life};
        qb = 1'b1;
      end
      o.rem = r2[31:0];
      o.quo = {a.quo[14:0], qb};
    end
    if (k == LerpStage) begin
      n90 = 23'(a.quo) * 23'd90;
      o.size = 23'(SizeZero) - n90;
      am = 32'(a.quo) * 32'(AlphaZero);
      o.alpha = 16'(AlphaZero) - am[31:16];
    end
    for (int i = 0; i < 3; i++) begin
      if (k == KickStage && i != 1) begin
        o.vel[i] = sat32(36'(a.vel[i]) + 36'($signed({1'b0, c.kick})));
      end
      if (k == WindStage) begin
        o.vel[i] = sat32(36'(a.vel[i]) + 36'(c.wind[i]));
      end
      if (k == DampStage) begin
        mf = a.vel[i] * c.fac;
        o.vel[i] = sat32(36'(mf >>> FracBits));
      end
      if (k == PosStage) begin
        mp = a.vel[i] * $signed({1'b0, c.dt});
        o.pos[i] = sat32(36'(a.pos[i]) + 36'(mp >>> FracBits));
      end
    end
    return o;
  endfunction

endpackage

@@ design/particle_euler_update_top.sv @@
// One explicit Euler step per particle: kick, wind, humidity damping, position and
// age update, then size and alpha lerped by age/lifetime; a particle whose new age
// reaches its lifetime is dropped with no output word. Fully pipelined: one particle
// per cycle while not stalled, through 19 register stages; the depth is set by the
// 16 one-bit quotient stages of age/lifetime. Stalls hold the pipeline only up to
// the first empty stage. Derived constants (kick, wind term, damping factor) settle
// through their registers before a particle accepted with or after the last
// configuration write reaches the stages that use them.
module particle_euler_update_top import peu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  in_pos_x_i,
  input  logic signed [31:0]  in_pos_y_i,
  input  logic signed [31:0]  in_pos_z_i,
  input  logic signed [31:0]  in_vel_x_i,
  input  logic signed [31:0]  in_vel_y_i,
  input  logic signed [31:0]  in_vel_z_i,
  input  logic [30:0]         in_age_i,
  input  logic [30:0]         in_lifetime_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  out_pos_x_o,
  output logic signed [31:0]  out_pos_y_o,
  output logic signed [31:0]  out_pos_z_o,
  output logic signed [31:0]  out_vel_x_o,
  output logic signed [31:0]  out_vel_y_o,
  output logic signed [31:0]  out_vel_z_o,
  output logic [30:0]         out_age_o,
  output logic [30:0]         out_lifetime_o,
  output logic [22:0]         out_size_o,
  output logic [15:0]         out_alpha_o
);

  logic [16:0]        dt_q;
  logic signed [17:0] wd_q [3];
  logic [23:0]        ws_q;
  logic [16:0]        hum_q;

  logic [13:0]        t_q, t_d;
  logic [11:0]        tt_q, tt_d;
  logic [9:0]         ttt_q, ttt_d;
  logic [13:0]        s_q, s_d;
  logic [13:0]        kick_q, kick_d;
  logic signed [42:0] wp_q [3];
  logic signed [42:0] wp_d [3];
  logic signed [28:0] w_q [3];
  logic signed [28:0] w_d [3];
  logic [33:0]        hd_q, hd_d;
  logic signed [18:0] fac_q, fac_d;

  logic [29:0]        tp;
  logic [27:0]        ttp;
  logic [25:0]        tttp;
  logic [25:0]        d6p;
  logic [29:0]        kp;
  logic signed [44:0] wm [3];

  pe_dcfg_t           dc;
  pe_st_t             st_q [NumStages];
  pe_st_t             st_d [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= '0;
      wd_q  <= '{default: '0};
      ws_q  <= '0;
      hum_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDeltaTime: dt_q    <= cfg_data_i[16:0];
        CfgWindX:     wd_q[0] <= cfg_data_i[17:0];
        CfgWindY:     wd_q[1] <= cfg_data_i[17:0];
        CfgWindZ:     wd_q[2] <= cfg_data_i[17:0];
        CfgWindStr:   ws_q    <= cfg_data_i;
        CfgHumidity:  hum_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tp     = 30'(dt_q) * 30'(Tenth);
    t_d    = tp[29:16];
    ttp    = 28'(t_q) * 28'(t_q);
    tt_d   = ttp[27:16];
    tttp   = 26'(tt_q) * 26'(t_q);
    ttt_d  = tttp[25:16];
    d6p    = 26'(ttt_q) * 26'(Recip6);
    s_d    = t_q - 14'(d6p >> Recip6Shift);
    kp     = 30'(s_q[13:1]) * 30'(dt_q);
    kick_d = kp[29:16];
    hd_d   = 34'(hum_q) * 34'(dt_q);
    fac_d  = 19'sd65536 - $signed({1'b0, hd_q[33:16]});
    for (int i = 0; i < 3; i++) begin
      wp_d[i] = wd_q[i] * $signed({1'b0, ws_q});
      wm[i]   = 45'(wp_q[i] >>> FracBits) * $signed({1'b0, dt_q});
      w_d[i]  = 29'(wm[i] >>> FracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q    <= '0;
      tt_q   <= '0;
      ttt_q  <= '0;
      s_q    <= '0;
      kick_q <= '0;
      wp_q   <= '{default: '0};
      w_q    <= '{default: '0};
      hd_q   <= '0;
      fac_q  <= '0;
    end else begin
      t_q    <= t_d;
      tt_q   <= tt_d;
      ttt_q  <= ttt_d;
      s_q    <= s_d;
      kick_q <= kick_d;
      wp_q   <= wp_d;
      w_q    <= w_d;
      hd_q   <= hd_d;
      fac_q  <= fac_d;
    end
  end

  always_comb begin
    dc.dt   = dt_q;
    dc.kick = kick_q;
    dc.wind = w_q;
    dc.fac  = fac_q;
  end

  // advance a stage when the next one is empty or advancing
  always_comb begin
    ready[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o = !ready[0];

  always_comb begin
    st_d[0].live  = 1'b1;
    st_d[0].pos[0] = in_pos_x_i;
    st_d[0].pos[1] = in_pos_y_i;
    st_d[0].pos[2] = in_pos_z_i;
    st_d[0].vel[0] = in_vel_x_i;
    st_d[0].vel[1] = in_vel_y_i;
    st_d[0].vel[2] = in_vel_z_i;
    st_d[0].age   = in_age_i;
    st_d[0].life  = in_lifetime_i;
    st_d[0].rem   = '0;
    st_d[0].quo   = '0;
    st_d[0].size  = '0;
    st_d[0].alpha = '0;
    for (int k = 0; k < NumStages - 1; k++) begin
      st_d[k+1] = pe_step(k, st_q[k], dc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1] && st_d[k].live;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o    = valid_q[NumStages-1];
  assign out_pos_x_o    = st_q[NumStages-1].pos[0];
  assign out_pos_y_o    = st_q[NumStages-1].pos[1];
  assign out_pos_z_o    = st_q[NumStages-1].pos[2];
  assign out_vel_x_o    = st_q[NumStages-1].vel[0];
  assign out_vel_y_o    = st_q[NumStages-1].vel[1];
  assign out_vel_z_o    = st_q[NumStages-1].vel[2];
  assign out_age_o      = st_q[NumStages-1].age;
  assign out_lifetime_o = st_q[NumStages-1].life;
  assign out_size_o     = st_q[NumStages-1].size;
  assign out_alpha_o    = st_q[NumStages-1].alpha;

  a_live_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_age_o < out_lifetime_o)
    else $error("emitted particle has reached its lifetime");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_alpha_o <= 16'(AlphaZero))
    else $error("alpha above start value");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_size_o <= 23'(SizeZero)) && (out_size_o >= 23'(SizeEnd)))
    else $error("size outside lerp range");

  a_drop_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && ready[1] && !st_d[1].live) |=> !valid_q[1])
    else $error("expired particle not dropped");

endmodule

@@ test/particle_euler_update_top_test.sv @@
module particle_euler_update_top_test;
  import peu_pkg::*;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic [30:0]        age;
    logic [30:0]        life;
    logic [22:0]        size;
    logic [15:0]        alpha;
  } particle_t;

  localparam longint One = 64'sd65536;
  localparam int WatchLimit = 20000;

  class particle_board;
    longint    dt, wx [3], wstr, hum;
    particle_t pending [$];
    int        mismatches;

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return p >>> 16;
      return -((-p + One - 1) >>> 16);
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [23:0] d);
      case (idx)
        CfgDeltaTime: dt = longint'(d[16:0]);
        CfgWindX: wx[0] = longint'($signed(d[17:0]));
        CfgWindY: wx[1] = longint'($signed(d[17:0]));
        CfgWindZ: wx[2] = longint'($signed(d[17:0]));
        CfgWindStr: wstr = longint'(d);
        CfgHumidity: hum = longint'(d[16:0]);
        default: ;
      endcase
    endfunction

    function void note_input(particle_t p);
      longint t, s, kick, fac, v, q, a, life, r;
      particle_t e;
      t = qmul(dt, (One + 5) / 10);
      s = t - qmul(qmul(t, t), t) / 6;
      kick = qmul(s >>> 1, dt);
      fac = One - qmul(hum, dt);
      for (int i = 0; i < 3; i++) begin
        v = longint'(p.vel[i]);
        if (i != 1) v = clip32(v + kick);
        v = clip32(v + qmul(qmul(wx[i], wstr), dt));
        v = clip32(qmul(v, fac));
        e.vel[i] = v[31:0];
        q = clip32(longint'(p.pos[i]) + qmul(v, dt));
        e.pos[i] = q[31:0];
      end
      a = longint'(p.age) + dt;
      if (a > 64'sd2147483647) a = 64'sd2147483647;
      life = longint'(p.life);
      if (a >= life) return;
      r = (a <<< 16) / life;
      e.age = a[30:0];
      e.life = life[30:0];
      e.size = 23'(100 * One - ((90 * One * r) >>> 16));
      q = (One * 4 + 2) / 5;
      e.alpha = 16'(q - ((q * r) >>> 16));
      pending = {pending, e};
    endfunction

    function void check_result(particle_t g);
      particle_t e;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: age %h", g.age);
        return;
      end
      e = pending.pop_front();
      bad = (e.age !== g.age) || (e.life !== g.life) || (e.size !== g.size)
            || (e.alpha !== g.alpha);
      for (int i = 0; i < 3; i++)
        if (e.pos[i] !== g.pos[i] || e.vel[i] !== g.vel[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp pos %h %h %h vel %h %h %h age %h life %h size %h alpha %h",
                   e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
                   e.age, e.life, e.size, e.alpha);
          $display("         got pos %h %h %h vel %h %h %h age %h life %h size %h alpha %h",
                   g.pos[0], g.pos[1], g.pos[2], g.vel[0], g.vel[1], g.vel[2],
                   g.age, g.life, g.size, g.alpha);
        end
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [2:0] cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic signed [31:0] in_pos_x_i, in_pos_y_i, in_pos_z_i, in_vel_x_i, in_vel_y_i, in_vel_z_i;
  logic [30:0] in_age_i, in_lifetime_i;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [31:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [30:0] out_age_o, out_lifetime_o;
  logic [22:0] out_size_o;
  logic [15:0] out_alpha_o;

  particle_board board;
  int  send_idle_pct, recv_stall_pct, watch;
  bit  failed;

  particle_euler_update_top dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      particle_t g;
      g.pos[0] = out_pos_x_o; g.pos[1] = out_pos_y_o; g.pos[2] = out_pos_z_o;
      g.vel[0] = out_vel_x_o; g.vel[1] = out_vel_y_o; g.vel[2] = out_vel_z_o;
      g.age = out_age_o; g.life = out_lifetime_o;
      g.size = out_size_o; g.alpha = out_alpha_o;
      board.check_result(g);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(cfg_reg_e idx, logic [23:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    board.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send(particle_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_pos_x_i <= p.pos[0]; in_pos_y_i <= p.pos[1]; in_pos_z_i <= p.pos[2];
    in_vel_x_i <= p.vel[0]; in_vel_y_i <= p.vel[1]; in_vel_z_i <= p.vel[2];
    in_age_i <= p.age; in_lifetime_i <= p.life;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(p);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h000fffff);
      3: return -$urandom_range(0, 32'h000fffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pick32();
      p.vel[i] = pick32();
    end
    case ($urandom_range(4))
      0: begin p.age = 31'($urandom); p.life = 31'($urandom); end
      1: begin p.age = 31'h7fff0000 | 31'($urandom); p.life = 31'h7fffffff; end
      2: begin p.age = 31'($urandom_range(0, 1000)); p.life = 0; end
      default: begin
        p.life = 31'($urandom_range(1, 32'h7ffffffe)) | 31'h00020000;
        p.age = 31'($urandom_range(0, p.life - 1)) >> $urandom_range(0, 8);
      end
    endcase
    return p;
  endfunction

  task automatic config_set(int k);
    case (k)
      0: begin
        write_reg(CfgDeltaTime, 0); write_reg(CfgWindX, 0); write_reg(CfgWindY, 0);
        write_reg(CfgWindZ, 0); write_reg(CfgWindStr, 0); write_reg(CfgHumidity, 0);
      end
      1: begin
        write_reg(CfgDeltaTime, 24'h010000); write_reg(CfgWindX, 24'h010000);
        write_reg(CfgWindY, 24'h030000); write_reg(CfgWindZ, 24'h020000);
        write_reg(CfgWindStr, 24'hffffff); write_reg(CfgHumidity, 24'h010000);
      end
      2: begin
        write_reg(CfgDeltaTime, 24'h1ffff); write_reg(CfgWindX, 24'h3ffff);
        write_reg(CfgWindY, 24'h1ffff); write_reg(CfgWindZ, 24'h20000);
        write_reg(CfgWindStr, 24'($urandom)); write_reg(CfgHumidity, 24'h1ffff);
      end
      default: begin
        write_reg(CfgDeltaTime, 24'($urandom_range(0, 65536)));
        write_reg(CfgWindX, 24'($signed($urandom_range(0, 131072)) - 65536));
        write_reg(CfgWindY, 24'($signed($urandom_range(0, 131072)) - 65536));
        write_reg(CfgWindZ, 24'($signed($urandom_range(0, 131072)) - 65536));
        write_reg(CfgWindStr, 24'($urandom_range(0, 24'h3fffff)));
        write_reg(CfgHumidity, 24'($urandom_range(0, 65536)));
      end
    endcase
  endtask

  initial begin
    particle_t p;
    board = new();
    send_idle_pct = 0; recv_stall_pct = 0; watch = 0;
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = CfgDeltaTime; cfg_data_i = 0;
    in_valid_i = 0;
    in_pos_x_i = 0; in_pos_y_i = 0; in_pos_z_i = 0;
    in_vel_x_i = 0; in_vel_y_i = 0; in_vel_z_i = 0;
    in_age_i = 0; in_lifetime_i = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (20) @(negedge clk_i);

    for (int c = 0; c < 3; c++) begin
      config_set(c);
      for (int j = 0; j < 8; j++) begin
        for (int i = 0; i < 3; i++) begin
          p.pos[i] = j[0] ? 32'h7fffffff : 32'h80000000;
          p.vel[i] = j[1] ? 32'h7fffffff : 32'h80000000;
        end
        case (j % 4)
          0: begin p.age = 0; p.life = 0; end
          1: begin p.age = 0; p.life = 31'h7fffffff; end
          2: begin p.age = 31'h7fffffff; p.life = 31'h7fffffff; end
          default: begin p.age = 31'h7ffeffff; p.life = 31'h7fffffff; end
        endcase
        send(p);
      end
      in_valid_i <= 0;
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      config_set(ph == 4 ? 2 : 3);
      for (int i = 0; i < 125; i++) send(rand_particle());
      in_valid_i <= 0;
      drain();
    end

    failed = board.mismatches != 0;
    if (failed) $display("CHECK FAILED");
    else $display("CHECK OK");
    $finish;
  end

endmodule
